[rtl/csrec_pkg.sv]
package csrec_pkg;

	localparam int STATIONS_DEF = 16;
	localparam int QUEUE_DEPTH  = 2;

	localparam int RATE_W     = 28;
	localparam int SCALE_W    = 18;
	localparam int PROD_W     = 32 + SCALE_W;
	localparam int DIV_CNT_W  = $clog2(RATE_W);
	localparam logic [SCALE_W-1:0] RATE_SCALE = 18'd256000;
	localparam logic [RATE_W-1:0]  RATE_MAX   = '1;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_GAP_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_GAP_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_DT_MIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_DT_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REORDER_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TS_BACK_LIMIT   = 3'd5;

	localparam logic [15:0] FILL_GAP_LIMIT_RST  = 16'd1024;
	localparam logic [31:0] DRAIN_GAP_LIMIT_RST = 32'd65535;
	localparam logic [31:0] DRAIN_DT_MIN_RST    = 32'd100;
	localparam logic [31:0] DRAIN_DT_MAX_RST    = 32'd60000;
	localparam logic [15:0] REORDER_LIMIT_RST   = 16'd1024;
	localparam logic [30:0] TS_BACK_LIMIT_RST   = 31'd60000;

	typedef enum logic [3:0] {
		OC_DUP       = 4'd0,
		OC_FIRST     = 4'd1,
		OC_SEQ       = 4'd2,
		OC_GAP       = 4'd3,
		OC_DRAIN     = 4'd4,
		OC_DRAIN_REJ = 4'd5,
		OC_RESYNC    = 4'd6,
		OC_REORDER   = 4'd7,
		OC_RESET     = 4'd8
	} outcome_t;

	typedef struct packed {
		logic [3:0]  station;
		logic [31:0] click_counter;
		logic [31:0] sender_time_ms;
		logic [31:0] local_time_ms;
	} in_word_t;

	typedef struct packed {
		outcome_t    outcome;
		logic [16:0] credit;
		logic [15:0] gap_fill;
	} out_word_t;

	typedef struct packed {
		logic [15:0] fill_gap_limit;
		logic [31:0] drain_gap_limit;
		logic [31:0] drain_dt_min;
		logic [31:0] drain_dt_max;
		logic [15:0] reorder_limit;
		logic [30:0] ts_back_limit;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  station;
		logic        station_ok;
		outcome_t    outcome;
		logic [16:0] credit;
		logic [15:0] gap_fill;
		logic [31:0] gap;
		logic [31:0] dt;
		logic [31:0] now;
	} cmd_t;

	typedef struct packed {
		logic [31:0] last_counter;
		logic [31:0] last_sender_time;
	} front_rec_t;

	typedef struct packed {
		logic [31:0]       last_credit_time;
		logic [15:0]       resync_total;
		logic [31:0]       gap_filled_total;
		logic [31:0]       drain_backlog;
		logic [RATE_W-1:0] peak_drain_rate;
	} back_rec_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CALC,
		F_DECIDE
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_PREP,
		B_CHECK,
		B_DIV,
		B_WRITE
	} back_state_t;

endpackage

[rtl/click_sequence_reconciler_core.sv]
// channel  dir  handshake             word
// in       in   in_valid / in_stall   in_word   (in_word_t)
// out      out  out_valid / out_stall out_word  (out_word_t)
// cfg      in   cfg_we                cfg_index, cfg_data
//
// Front takes a word through F_CALC, F_DECIDE before the next; the back through B_PREP,
// B_WRITE; drain words add B_CHECK and, unless the rate clips, a 28-step serial divider.
// A two-entry command queue lets the front run ahead while the back divides.
// Reset clears the per-station valid bits at once; no clearing pass is needed.
// A stalled result holds in the output register; the back then holds and the queue fills.
module click_sequence_reconciler_core import csrec_pkg::*; #(
	parameter int STATIONS = STATIONS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_t cfg_q;
	logic push;
	logic full;
	logic pop;
	logic q_valid;
	cmd_t cmd_in;
	cmd_t cmd_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fill_gap_limit  <= FILL_GAP_LIMIT_RST;
			cfg_q.drain_gap_limit <= DRAIN_GAP_LIMIT_RST;
			cfg_q.drain_dt_min    <= DRAIN_DT_MIN_RST;
			cfg_q.drain_dt_max    <= DRAIN_DT_MAX_RST;
			cfg_q.reorder_limit   <= REORDER_LIMIT_RST;
			cfg_q.ts_back_limit   <= TS_BACK_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FILL_GAP_LIMIT:  cfg_q.fill_gap_limit  <= cfg_data[15:0];
				CFG_DRAIN_GAP_LIMIT: cfg_q.drain_gap_limit <= cfg_data;
				CFG_DRAIN_DT_MIN:    cfg_q.drain_dt_min    <= cfg_data;
				CFG_DRAIN_DT_MAX:    cfg_q.drain_dt_max    <= cfg_data;
				CFG_REORDER_LIMIT:   cfg_q.reorder_limit   <= cfg_data[15:0];
				CFG_TS_BACK_LIMIT:   cfg_q.ts_back_limit   <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	csrec_front #(
		.STATIONS(STATIONS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.cfg      (cfg_q),
		.push     (push),
		.cmd      (cmd_in),
		.full     (full)
	);

	csrec_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (pop),
		.rdata  (cmd_out),
		.valid  (q_valid)
	);

	csrec_back #(
		.STATIONS(STATIONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.pop       (pop),
		.cmd       (cmd_out),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

[rtl/csrec_queue.sv]
module csrec_queue import csrec_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t rdata,
	output logic valid
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           ent_q [QUEUE_DEPTH];
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  rp_q;
	logic [CW-1:0]  cnt_q;

	assign full  = (cnt_q == CW'(QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> valid)
		else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

[rtl/csrec_front.sv]
module csrec_front import csrec_pkg::*; #(
	parameter int STATIONS = STATIONS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_word,
	input  cfg_t     cfg,
	output logic     push,
	output cmd_t     cmd,
	input  logic     full
);

	localparam int AW = (STATIONS > 1) ? $clog2(STATIONS) : 1;

	front_state_t  state_q;
	front_state_t  state_d;
	front_rec_t    mem_q [STATIONS];
	logic [STATIONS-1:0] vld_q;
	front_rec_t    rec_q;
	logic          rec_vld_q;
	in_word_t      item_q;
	logic          item_ok_q;

	logic          in_fire;
	logic          in_ok;
	logic [AW-1:0] in_idx;
	logic [AW-1:0] item_idx;
	logic [31:0]   lc;
	logic [31:0]   ls;
	logic [32:0]   back_ext;

	logic [31:0]   gap_q;
	logic [31:0]   dt_q;
	logic [31:0]   back_q;
	logic [31:0]   mag_q;
	logic          gt_q;
	logic          eq_q;
	logic          first_q;

	outcome_t      oc;
	logic [16:0]   credit;
	logic [15:0]   gcredit;
	logic          adv;

	assign in_stall = (state_q != F_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign in_ok    = ({28'd0, in_word.station} < 32'(STATIONS));
	assign in_idx   = AW'(in_word.station);
	assign item_idx = AW'(item_q.station);
	assign lc       = rec_vld_q ? rec_q.last_counter : '0;
	assign ls       = rec_vld_q ? rec_q.last_sender_time : '0;
	assign back_ext = {1'b0, lc} - {1'b0, item_q.click_counter};
	assign push     = (state_q == F_DECIDE) && !full;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_word;
			rec_q  <= mem_q[in_idx];
		end
		if (push && item_ok_q && adv) begin
			mem_q[item_idx] <= '{last_counter: item_q.click_counter,
				last_sender_time: item_q.sender_time_ms};
		end
		if (state_q == F_CALC) begin
			gap_q   <= item_q.click_counter - lc - 32'd1;
			dt_q    <= item_q.sender_time_ms - ls;
			mag_q   <= ls - item_q.sender_time_ms;
			back_q  <= back_ext[31:0];
			gt_q    <= back_ext[32];
			eq_q    <= (item_q.click_counter == lc);
			first_q <= (lc == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			vld_q     <= '0;
			rec_vld_q <= 1'b0;
			item_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				item_ok_q <= in_ok;
				rec_vld_q <= in_ok && vld_q[in_idx];
			end
			if (push && item_ok_q && adv) begin
				vld_q[item_idx] <= 1'b1;
			end
		end
	end

	always_comb begin
		oc      = OC_DUP;
		credit  = '0;
		gcredit = '0;
		adv     = 1'b0;
		if (item_ok_q) begin
			if (first_q) begin
				oc     = OC_FIRST;
				credit = 17'd1;
				adv    = 1'b1;
			end else if (eq_q) begin
				oc = OC_DUP;
			end else if (gt_q) begin
				credit = 17'd1;
				adv    = 1'b1;
				if (gap_q == '0) begin
					oc = OC_SEQ;
				end else if (gap_q <= {16'd0, cfg.fill_gap_limit}) begin
					oc      = OC_GAP;
					credit  = 17'd1 + {1'b0, gap_q[15:0]};
					gcredit = gap_q[15:0];
				end else if (gap_q <= cfg.drain_gap_limit) begin
					if (dt_q > cfg.drain_dt_min && dt_q < cfg.drain_dt_max) begin
						oc = OC_DRAIN;
					end else begin
						oc = OC_DRAIN_REJ;
					end
				end else begin
					oc = OC_RESYNC;
				end
			end else begin
				if (back_q > {16'd0, cfg.reorder_limit} ||
					(dt_q[31] && mag_q > {1'b0, cfg.ts_back_limit})) begin
					oc     = OC_RESET;
					credit = 17'd1;
					adv    = 1'b1;
				end else begin
					oc = OC_REORDER;
				end
			end
		end
	end

	always_comb begin
		cmd.station    = item_q.station;
		cmd.station_ok = item_ok_q;
		cmd.outcome    = oc;
		cmd.credit     = credit;
		cmd.gap_fill   = gcredit;
		cmd.gap        = gap_q;
		cmd.dt         = dt_q;
		cmd.now        = item_q.local_time_ms;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (in_fire) begin
					state_d = F_CALC;
				end
			end
			F_CALC: begin
				state_d = F_DECIDE;
			end
			F_DECIDE: begin
				if (!full) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

endmodule

[rtl/csrec_back.sv]
module csrec_back import csrec_pkg::*; #(
	parameter int STATIONS = STATIONS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      pop,
	input  cmd_t      cmd,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	localparam int AW = (STATIONS > 1) ? $clog2(STATIONS) : 1;

	back_state_t          state_q;
	back_state_t          state_d;
	back_rec_t            mem_q [STATIONS];
	logic [STATIONS-1:0]  vld_q;
	back_rec_t            rd_q;
	logic                 rd_vld_q;
	back_rec_t            rec;
	back_rec_t            upd_q;
	back_rec_t            wr_rec;
	cmd_t                 cmd_q;
	logic [AW-1:0]        cmd_idx;
	logic [AW-1:0]        pop_idx;

	logic [PROD_W-1:0]    prod_d;
	logic [PROD_W-1:0]    prod_q;
	logic                 sat;
	logic [31:0]          rem_q;
	logic [RATE_W-1:0]    num_q;
	logic [RATE_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [32:0]          rem_sh;
	logic [32:0]          rem_sub;
	logic                 div_last;
	logic                 bump;

	logic                 wr_fire;
	out_word_t            out_word_q;
	logic                 out_valid_q;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

	assign pop      = (state_q == B_IDLE) && q_valid;
	assign pop_idx  = AW'(cmd.station);
	assign cmd_idx  = AW'(cmd_q.station);
	assign rec      = rd_vld_q ? rd_q : '0;
	assign prod_d   = cmd_q.gap * RATE_SCALE;
	assign sat      = {{(32 + RATE_W - PROD_W){1'b0}}, prod_q} >= {cmd_q.dt, {RATE_W{1'b0}}};
	assign rem_sh   = {rem_q, num_q[RATE_W-1]};
	assign rem_sub  = rem_sh - {1'b0, cmd_q.dt};
	assign div_last = (cnt_q == DIV_CNT_W'(RATE_W - 1));
	assign bump     = (cmd_q.outcome == OC_DRAIN_REJ) || (cmd_q.outcome == OC_RESYNC) ||
		(cmd_q.outcome == OC_RESET);
	assign wr_fire  = (state_q == B_WRITE) && (!out_valid_q || !out_stall);

	always_comb begin
		wr_rec = upd_q;
		if (quo_q > upd_q.peak_drain_rate) begin
			wr_rec.peak_drain_rate = quo_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
			rd_q  <= mem_q[pop_idx];
		end
		case (state_q)
			B_PREP: begin
				upd_q.last_credit_time <= (cmd_q.credit != '0) ? cmd_q.now :
					rec.last_credit_time;
				upd_q.gap_filled_total <= sat_add32(rec.gap_filled_total,
					{16'd0, cmd_q.gap_fill});
				upd_q.resync_total     <= (bump && rec.resync_total != '1) ?
					rec.resync_total + 16'd1 : rec.resync_total;
				upd_q.drain_backlog    <= (cmd_q.outcome == OC_DRAIN) ?
					sat_add32(rec.drain_backlog, cmd_q.gap) : rec.drain_backlog;
				upd_q.peak_drain_rate  <= rec.peak_drain_rate;
				prod_q <= prod_d;
				quo_q  <= '0;
			end
			B_CHECK: begin
				if (sat) begin
					quo_q <= RATE_MAX;
				end else begin
					rem_q <= 32'(prod_q[PROD_W-1:RATE_W]);
					num_q <= prod_q[RATE_W-1:0];
					cnt_q <= '0;
				end
			end
			B_DIV: begin
				rem_q <= rem_sub[32] ? rem_sh[31:0] : rem_sub[31:0];
				quo_q <= {quo_q[RATE_W-2:0], ~rem_sub[32]};
				num_q <= {num_q[RATE_W-2:0], 1'b0};
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			B_WRITE: begin
				if (wr_fire) begin
					if (cmd_q.station_ok) begin
						mem_q[cmd_idx] <= wr_rec;
					end
					out_word_q <= '{outcome: cmd_q.outcome, credit: cmd_q.credit,
						gap_fill: cmd_q.gap_fill};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				rd_vld_q <= cmd.station_ok && vld_q[pop_idx];
			end
			if (wr_fire && cmd_q.station_ok) begin
				vld_q[cmd_idx] <= 1'b1;
			end
			if (wr_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					state_d = B_PREP;
				end
			end
			B_PREP: begin
				state_d = (cmd_q.outcome == OC_DRAIN) ? B_CHECK : B_WRITE;
			end
			B_CHECK: begin
				state_d = sat ? B_WRITE : B_DIV;
			end
			B_DIV: begin
				if (div_last) begin
					state_d = B_WRITE;
				end
			end
			B_WRITE: begin
				if (wr_fire) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_div_drain_only: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> cmd_q.outcome == OC_DRAIN)
		else $error("divider running for a non-drain word");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> cnt_q <= DIV_CNT_W'(RATE_W - 1))
		else $error("divider step count overrun");
	a_write_shows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_fire |=> out_valid_q && state_q == B_IDLE)
		else $error("result word not presented after record write");

endmodule
